// ===== rtl/sgdc_pkg.sv =====
package sgdc_pkg;

   localparam int POS_W        = 16;
   localparam int NODE_INDEX_W = 9;
   localparam int VALUE_W      = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int RADIUS_W     = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ORIGIN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_SQUARED = 2'd2;

   localparam logic KIND_DEPOSIT = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   localparam logic [POS_W-1:0]    ORIGIN_RESET = 16'd4096;
   localparam logic [POS_W-1:0]    STEP_RESET   = 16'd8192;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'd16777216;

   localparam logic [VALUE_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic clear_en;
      logic walk_start;
      logic walk_step;
      logic read_start;
      logic read_fetch;
      logic load_rsp;
      logic rsp_from_read;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_last;
      logic pipe_busy;
   } status_type;

endpackage

// ===== rtl/sgdc_ctrl.sv =====
module sgdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_stall,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   input  sgdc_pkg::status_type status,
   output sgdc_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      WALK,
      DRAIN,
      READ,
      DELIVER
   } state_type;

   state_type state_ff;
   logic      read_item_ff;
   logic      rsp_valid_ff;
   logic      req_take;

   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd               = '0;
      cmd.clear_en      = (state_ff == CLEAR);
      cmd.walk_start    = req_take && (req_kind == sgdc_pkg::KIND_DEPOSIT);
      cmd.read_start    = req_take && (req_kind == sgdc_pkg::KIND_READ);
      cmd.walk_step     = (state_ff == WALK);
      cmd.read_fetch    = (state_ff == READ);
      cmd.load_rsp      = (state_ff == DELIVER) && (!rsp_valid_ff || !rsp_stall);
      cmd.rsp_from_read = read_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         read_item_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (req_take) begin
                  read_item_ff <= (req_kind == sgdc_pkg::KIND_READ);
                  state_ff     <= (req_kind == sgdc_pkg::KIND_READ) ? READ : WALK;
               end
            end
            WALK: begin
               if (status.walk_last) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (!status.pipe_busy) begin
                  state_ff <= DELIVER;
               end
            end
            READ: begin
               state_ff <= DELIVER;
            end
            DELIVER: begin
               if (cmd.load_rsp) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // A request must never enter while node updates are still in flight.
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> !status.pipe_busy)
      else $error("request accepted while the node pipeline is busy");

   // A result may only be loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a pending response");

   // The node walk stops after the last node.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && status.walk_last) |=> !cmd.walk_step)
      else $error("node walk continued past the last node");

endmodule

// ===== rtl/sgdc_datapath.sv =====
module sgdc_datapath #(
   parameter int NODES_PER_AXIS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sgdc_pkg::cmd_type                      cmd,
   output sgdc_pkg::status_type                   status,
   input  logic [sgdc_pkg::POS_W-1:0]             req_pos_x,
   input  logic [sgdc_pkg::POS_W-1:0]             req_pos_y,
   input  logic [sgdc_pkg::POS_W-1:0]             req_pos_z,
   input  logic [sgdc_pkg::NODE_INDEX_W-1:0]      req_node_index,
   input  logic                                   csr_write_enable,
   input  logic [sgdc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sgdc_pkg::CSR_DATA_W-1:0]        csr_write_data,
   output logic [sgdc_pkg::VALUE_W-1:0]           rsp_value,
   output logic                                   rsp_saturated
);

   localparam int AXIS_W     = $clog2(NODES_PER_AXIS);
   localparam int NODE_TOTAL = NODES_PER_AXIS * NODES_PER_AXIS * NODES_PER_AXIS;
   localparam int ADDR_W     = $clog2(NODE_TOTAL);
   localparam int COORD_W    = sgdc_pkg::POS_W + AXIS_W;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int VALUE_W    = sgdc_pkg::VALUE_W;

   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NODES_PER_AXIS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(NODE_TOTAL - 1);

   logic [sgdc_pkg::POS_W-1:0]  origin_ff;
   logic [sgdc_pkg::POS_W-1:0]  step_ff;
   logic [sgdc_pkg::RADIUS_W-1:0] radius_ff;

   logic [VALUE_W-1:0] mem [NODE_TOTAL];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0] clr_addr_ff;

   logic [sgdc_pkg::POS_W-1:0] px_ff, py_ff, pz_ff;
   logic [AXIS_W-1:0]  i_ff, j_ff, k_ff;
   logic [ADDR_W-1:0]  flat_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff, cz_ff;

   logic               v1_ff, v2_ff, v3_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [ADDR_W-1:0]  flat1_ff, flat2_ff, flat3_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic               hit3_ff;

   logic [VALUE_W-1:0] hits_ff;
   logic               sat_ff;

   logic [ADDR_W-1:0]  read_addr_ff;
   logic               read_in_range_ff;

   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_saturated_ff;

   logic [COORD_W-1:0] px_ext, py_ext, pz_ext, origin_ext;
   logic [SUM_W-1:0]   dist_sum;
   logic               hit_in;
   logic [VALUE_W-1:0] count_in;
   logic               node_write;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;

   assign px_ext     = COORD_W'(px_ff);
   assign py_ext     = COORD_W'(py_ff);
   assign pz_ext     = COORD_W'(pz_ff);
   assign origin_ext = COORD_W'(origin_ff);

   assign status.clear_last = (clr_addr_ff == ADDR_LAST);
   assign status.walk_last  = (flat_ff == ADDR_LAST);
   assign status.pipe_busy  = v1_ff || v2_ff || v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= sgdc_pkg::ORIGIN_RESET;
         step_ff   <= sgdc_pkg::STEP_RESET;
         radius_ff <= sgdc_pkg::RADIUS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sgdc_pkg::CSR_GRID_ORIGIN: begin
               origin_ff <= csr_write_data[sgdc_pkg::POS_W-1:0];
            end
            sgdc_pkg::CSR_GRID_STEP: begin
               step_ff <= csr_write_data[sgdc_pkg::POS_W-1:0];
            end
            sgdc_pkg::CSR_RADIUS_SQUARED: begin
               radius_ff <= csr_write_data[sgdc_pkg::RADIUS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en && !status.clear_last) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pz_ff   <= req_pos_z;
         i_ff    <= '0;
         j_ff    <= '0;
         k_ff    <= '0;
         flat_ff <= '0;
         cx_ff   <= origin_ext;
         cy_ff   <= origin_ext;
         cz_ff   <= origin_ext;
      end else if (cmd.walk_step) begin
         flat_ff <= flat_ff + ADDR_W'(1);
         if (k_ff != AXIS_LAST) begin
            k_ff  <= k_ff + AXIS_W'(1);
            cz_ff <= cz_ff + COORD_W'(step_ff);
         end else begin
            k_ff  <= '0;
            cz_ff <= origin_ext;
            if (j_ff != AXIS_LAST) begin
               j_ff  <= j_ff + AXIS_W'(1);
               cy_ff <= cy_ff + COORD_W'(step_ff);
            end else begin
               j_ff  <= '0;
               cy_ff <= origin_ext;
               i_ff  <= i_ff + AXIS_W'(1);
               cx_ff <= cx_ff + COORD_W'(step_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.walk_step;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign dist_sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
   assign hit_in   = dist_sum < SUM_W'(radius_ff);

   always_ff @(posedge clock) begin
      dx_ff    <= (cx_ff >= px_ext) ? (cx_ff - px_ext) : (px_ext - cx_ff);
      dy_ff    <= (cy_ff >= py_ext) ? (cy_ff - py_ext) : (py_ext - cy_ff);
      dz_ff    <= (cz_ff >= pz_ext) ? (cz_ff - pz_ext) : (pz_ext - cz_ff);
      flat1_ff <= flat_ff;
      sqx_ff   <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff   <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sqz_ff   <= SQ_W'(dz_ff) * SQ_W'(dz_ff);
      flat2_ff <= flat1_ff;
      hit3_ff  <= hit_in;
      flat3_ff <= flat2_ff;
   end

   assign count_in   = (rd_data_ff == sgdc_pkg::COUNT_MAX) ? rd_data_ff
                                                           : rd_data_ff + VALUE_W'(1);
   assign node_write = v3_ff && hit3_ff;

   always_comb begin
      if (cmd.clear_en) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = node_write;
         mem_wr_addr = flat3_ff;
         mem_wr_data = count_in;
      end
      mem_rd_en   = v2_ff || cmd.read_fetch;
      mem_rd_addr = v2_ff ? flat2_ff : read_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         hits_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (node_write) begin
         hits_ff <= hits_ff + VALUE_W'(1);
         if (count_in == sgdc_pkg::COUNT_MAX) begin
            sat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         read_addr_ff     <= ADDR_W'(req_node_index);
         read_in_range_ff <= (32'(req_node_index) < 32'(NODE_TOTAL));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (cmd.rsp_from_read) begin
            rsp_value_ff     <= read_in_range_ff ? rd_data_ff : '0;
            rsp_saturated_ff <= 1'b0;
         end else begin
            rsp_value_ff     <= hits_ff;
            rsp_saturated_ff <= sat_ff;
         end
      end
   end

   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // The clearing pass and node updates share the write port and must never overlap.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> !status.pipe_busy)
      else $error("node update overlaps the clearing pass");

endmodule

// ===== rtl/sphere_grid_density_counter.sv =====
// Sphere grid density counter.
// Requests enter on the req_ channel (req_valid, req_stall) and each one
// produces exactly one response on the rsp_ channel (rsp_valid, rsp_stall).
// A deposit request (req_kind low) walks all NODES_PER_AXIS cubed grid
// nodes, one node per cycle through a read-modify-write of the count
// memory, and answers with the number of nodes hit and a saturation flag.
// A read request (req_kind high) returns one node count, fetched in the READ
// state and loaded into the output register in the DELIVER state.
// One request is processed at a time; a new request is accepted while the
// previous response still waits in the output register.
// After reset the block sweeps the count memory to zero, one node per
// cycle, and holds req_stall high meanwhile.
// Register writes on the csr_ port are taken at any time but are meant to
// happen only while the block is idle.
// When the receiver stalls, the response holds and the block waits before
// delivering the next one.
module sphere_grid_density_counter #(
   parameter int NODES_PER_AXIS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [sgdc_pkg::POS_W-1:0]          req_pos_x,
   input  logic [sgdc_pkg::POS_W-1:0]          req_pos_y,
   input  logic [sgdc_pkg::POS_W-1:0]          req_pos_z,
   input  logic [sgdc_pkg::NODE_INDEX_W-1:0]   req_node_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sgdc_pkg::VALUE_W-1:0]        rsp_value,
   output logic                                rsp_saturated,
   input  logic                                csr_write_enable,
   input  logic [sgdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgdc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   sgdc_pkg::cmd_type    cmd;
   sgdc_pkg::status_type status;

   sgdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   sgdc_datapath #(
      .NODES_PER_AXIS (NODES_PER_AXIS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_node_index   (req_node_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_value        (rsp_value),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// ===== test/tb_sphere_grid_density_counter.sv =====
`timescale 1ns / 1ps

module tb_sphere_grid_density_counter;

   localparam int NODES_PER_AXIS = 8;
   localparam int NODE_TOTAL = NODES_PER_AXIS * NODES_PER_AXIS * NODES_PER_AXIS;
   localparam int ITEMS_PER_PHASE = 115;
   localparam int HOLD_OFF_CYCLES = 3000;

   localparam logic KIND_DEPOSIT = sgdc_pkg::KIND_DEPOSIT;
   localparam logic KIND_READ    = sgdc_pkg::KIND_READ;
   localparam logic [sgdc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [sgdc_pkg::VALUE_W-1:0] value;
      logic                         saturated;
   } density_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_kind = KIND_READ;
   logic [sgdc_pkg::POS_W-1:0]          req_pos_x = '0;
   logic [sgdc_pkg::POS_W-1:0]          req_pos_y = '0;
   logic [sgdc_pkg::POS_W-1:0]          req_pos_z = '0;
   logic [sgdc_pkg::NODE_INDEX_W-1:0]   req_node_index = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [sgdc_pkg::VALUE_W-1:0]        rsp_value;
   logic                                rsp_saturated;
   logic                                csr_write_enable = 1'b0;
   logic [sgdc_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [sgdc_pkg::CSR_DATA_W-1:0]     csr_write_data = '0;

   logic [sgdc_pkg::POS_W-1:0]          cfg_origin = sgdc_pkg::ORIGIN_RESET;
   logic [sgdc_pkg::POS_W-1:0]          cfg_step = sgdc_pkg::STEP_RESET;
   logic [sgdc_pkg::RADIUS_W-1:0]       cfg_radius_sq = sgdc_pkg::RADIUS_RESET;
   logic [sgdc_pkg::VALUE_W-1:0]        node_tally [NODE_TOTAL];

   density_result_type       expected_results [$];
   int                       fail_count = 0;
   int                       stall_left = 0;
   int                       hold_left = 0;
   bit                       idling_on = 1'b1;

   sphere_grid_density_counter #(
      .NODES_PER_AXIS(NODES_PER_AXIS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_node_index(req_node_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_saturated(rsp_saturated),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [39:0] axis_square(int idx, logic [sgdc_pkg::POS_W-1:0] point);
      logic [19:0] node_pos;
      logic [19:0] diff;
      node_pos = 20'(cfg_origin) + 20'(cfg_step) * 20'(idx);
      diff = (node_pos >= 20'(point)) ? node_pos - 20'(point) : 20'(point) - node_pos;
      return 40'(diff) * 40'(diff);
   endfunction

   // Deposits update the tally copy as they are predicted, in request order.
   function automatic density_result_type predict_density(logic kind,
         logic [sgdc_pkg::POS_W-1:0] x, logic [sgdc_pkg::POS_W-1:0] y,
         logic [sgdc_pkg::POS_W-1:0] z, logic [sgdc_pkg::NODE_INDEX_W-1:0] idx);
      density_result_type r;
      logic [41:0] dist_sq;
      int unsigned hits;
      int i;
      int j;
      int k;
      int flat;
      r.value = '0;
      r.saturated = 1'b0;
      if (kind == KIND_READ) begin
         if (int'(idx) < NODE_TOTAL) r.value = node_tally[idx];
         return r;
      end
      hits = 0;
      for (i = 0; i < NODES_PER_AXIS; i++) begin
         for (j = 0; j < NODES_PER_AXIS; j++) begin
            for (k = 0; k < NODES_PER_AXIS; k++) begin
               dist_sq = 42'(axis_square(i, x)) + 42'(axis_square(j, y))
                         + 42'(axis_square(k, z));
               if (dist_sq < 42'(cfg_radius_sq)) begin
                  flat = (i * NODES_PER_AXIS + j) * NODES_PER_AXIS + k;
                  if (node_tally[flat] != sgdc_pkg::COUNT_MAX)
                     node_tally[flat] = node_tally[flat] + 1'b1;
                  if (node_tally[flat] == sgdc_pkg::COUNT_MAX) r.saturated = 1'b1;
                  hits++;
               end
            end
         end
      end
      r.value = sgdc_pkg::VALUE_W'(hits);
      return r;
   endfunction

   always @(posedge clock) begin
      density_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("rsp_value: no response expected, actual %0d", rsp_value);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_value !== want.value) begin
               $error("rsp_value: expected %0d, actual %0d", want.value, rsp_value);
               fail_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("rsp_saturated: expected %0b, actual %0b", want.saturated, rsp_saturated);
               fail_count++;
            end
         end
         stall_left = idling_on ? $urandom_range(0, 19) : 0;
      end else if (rsp_valid && stall_left > 0) begin
         stall_left--;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || (stall_left > 0);
   end

   task automatic send_request(input logic kind, input logic [sgdc_pkg::POS_W-1:0] x,
         input logic [sgdc_pkg::POS_W-1:0] y, input logic [sgdc_pkg::POS_W-1:0] z,
         input logic [sgdc_pkg::NODE_INDEX_W-1:0] idx);
      int gap;
      gap = idling_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_node_index <= idx;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_density(kind, x, y, z, idx));
   endtask

   task automatic wait_drained(input int settle_cycles);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
   endtask

   // The unused index is written each time as well; it must leave the grid unchanged.
   task automatic program_grid(input logic [sgdc_pkg::POS_W-1:0] origin,
         input logic [sgdc_pkg::POS_W-1:0] step,
         input logic [sgdc_pkg::RADIUS_W-1:0] radius_sq);
      csr_write_enable <= 1'b1;
      csr_index <= sgdc_pkg::CSR_GRID_ORIGIN;
      csr_write_data <= {16'($urandom), origin};
      @(posedge clock);
      cfg_origin = origin;
      csr_index <= sgdc_pkg::CSR_GRID_STEP;
      csr_write_data <= {16'($urandom), step};
      @(posedge clock);
      cfg_step = step;
      csr_index <= sgdc_pkg::CSR_RADIUS_SQUARED;
      csr_write_data <= radius_sq;
      @(posedge clock);
      cfg_radius_sq = radius_sq;
      csr_index <= CSR_UNUSED_INDEX;
      csr_write_data <= $urandom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_request();
      logic kind;
      logic [sgdc_pkg::POS_W-1:0] p [3];
      int c;
      int n;
      kind = ($urandom_range(0, 99) < 35) ? KIND_DEPOSIT : KIND_READ;
      for (n = 0; n < 3; n++) begin
         if ($urandom_range(0, 1)) begin
            c = int'(cfg_origin) + int'(cfg_step) * int'($urandom_range(0, NODES_PER_AXIS - 1))
                + int'($urandom_range(0, 4096)) - 2048;
            if (c < 0) c = 0;
            if (c > 65535) c = 65535;
            p[n] = sgdc_pkg::POS_W'(c);
         end else begin
            p[n] = sgdc_pkg::POS_W'($urandom);
         end
      end
      send_request(kind, p[0], p[1], p[2], sgdc_pkg::NODE_INDEX_W'($urandom));
   endtask

   task automatic test_directed_defaults();
      send_request(KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0);
      send_request(KIND_DEPOSIT, 16'd4096, 16'd4096, 16'd4096, 9'h1FF);
      send_request(KIND_DEPOSIT, 16'd8192, 16'd4096, 16'd4096, 9'd0);
      send_request(KIND_DEPOSIT, 16'd8191, 16'd4096, 16'd4096, 9'd0);
      send_request(KIND_DEPOSIT, 16'd0, 16'd0, 16'd0, 9'd0);
      send_request(KIND_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0);
      send_request(KIND_DEPOSIT, 16'd61440, 16'd61440, 16'd61440, 9'h155);
      send_request(KIND_READ, 16'd0, 16'd0, 16'd0, 9'd0);
      send_request(KIND_READ, 16'd0, 16'd0, 16'd0, 9'h1FF);
      send_request(KIND_READ, 16'hAAAA, 16'h5555, 16'hAAAA, 9'h155);
      send_request(KIND_READ, 16'h5555, 16'hAAAA, 16'h5555, 9'h0AA);
   endtask

   task automatic test_register_extremes();
      wait_drained(4);
      program_grid(16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send_request(KIND_DEPOSIT, 16'd0, 16'd0, 16'd0, 9'd0);
      send_request(KIND_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0);
      send_request(KIND_READ, 16'd0, 16'd0, 16'd0, 9'h1FF);
      wait_drained(4);
      program_grid(16'hFFFF, 16'hFFFF, 32'h0000_0000);
      send_request(KIND_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0);
      wait_drained(4);
      program_grid(16'hFFFF, 16'hFFFF, 32'h0000_0001);
      send_request(KIND_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0);
      send_request(KIND_READ, 16'd0, 16'd0, 16'd0, 9'd0);
      wait_drained(4);
      program_grid(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(KIND_DEPOSIT, 16'd32768, 16'd32768, 16'd32768, 9'd0);
      send_request(KIND_READ, 16'd0, 16'd0, 16'd0, 9'd73);
   endtask

   task automatic test_output_backpressure();
      int n;
      wait_drained(4);
      idling_on = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      for (n = 0; n < 12; n++) begin
         send_request((n < 3) ? KIND_DEPOSIT : KIND_READ, sgdc_pkg::POS_W'($urandom),
                      sgdc_pkg::POS_W'($urandom), sgdc_pkg::POS_W'($urandom),
                      sgdc_pkg::NODE_INDEX_W'($urandom));
      end
      wait_drained(4);
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      int unsigned r;
      for (phase = 0; phase < 10; phase++) begin
         wait_drained(4);
         idling_on = (phase % 4 != 3);
         r = $urandom_range(512, 16000);
         case (phase)
            0: program_grid(sgdc_pkg::ORIGIN_RESET, sgdc_pkg::STEP_RESET,
                            sgdc_pkg::RADIUS_RESET);
            1: program_grid(16'h0000, 16'h0000, 32'hFFFF_FFFF);
            2: program_grid(16'hFFFF, 16'hFFFF, 32'h0000_0000);
            9: program_grid(sgdc_pkg::POS_W'($urandom_range(0, 16383)),
                            sgdc_pkg::POS_W'($urandom_range(1024, 12000)),
                            sgdc_pkg::RADIUS_W'($urandom));
            default: program_grid(sgdc_pkg::POS_W'($urandom_range(0, 16383)),
                                  sgdc_pkg::POS_W'($urandom_range(1024, 12000)),
                                  sgdc_pkg::RADIUS_W'(r * r));
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
      end
   endtask

   initial begin
      foreach (node_tally[n]) node_tally[n] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_drained(NODE_TOTAL + 64);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sgdc_pkg.sv
rtl/sgdc_ctrl.sv
rtl/sgdc_datapath.sv
rtl/sphere_grid_density_counter.sv
test/tb_sphere_grid_density_counter.sv
